// File: rtl/prl_pkg.sv
// Shared definitions for the positional record list.
// Holds the capacity, field widths, opcodes and the stored record type.
// No dependencies.
package prl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KEY_W    = 8;
   localparam int NAME_W   = 64;
   localparam int AGE_W    = 8;
   localparam int OP_W     = 3;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 1;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

   typedef struct packed {
      logic [IDX_W-1:0]  key;
      logic [NAME_W-1:0] name;
      logic [AGE_W-1:0]  age;
   } rec_type;

endpackage

// File: rtl/positional_record_list_top.sv
// Positional record list: dense record store with insert, delete, search, clear, list.
// Depends on prl_pkg; one record memory with a registered read port.
//
// The block holds up to 64 records in one memory and accepts one command at a
// time; req_tready is high only while the sequencer is idle, and a finished
// beat waits in the output register, so the next command may be taken before
// it is drained. Search, clear, rejected and unknown commands go straight to
// the result beat. Insert shifts the records from the end down to key k, delete
// shifts those after key k, and list emits every record in turn; each result
// beat waits until the output register is free. Each shifted record is read
// from memory and then written back, each listed record is read and then
// emitted, and a single +1/-1 step adjusts the moved keys and the slot pointer.
module positional_record_list_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] key, [71:8] name_tag, [79:72] age
   input  logic [prl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] opcode
   input  logic [prl_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] ok, [6:1] found_index, [13:7] count, [19:14] entry_key,
   // [83:20] entry_name, [91:84] entry_age, [95:92] zero
   output logic [prl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] entry_valid
   output logic [prl_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast
);
   import prl_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1;
   localparam logic [2:0] ST_WR    = 3'd2;
   localparam logic [2:0] ST_LRD   = 3'd3;
   localparam logic [2:0] ST_LEMIT = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [AGE_W-1:0]  age_ff, age_in;
   logic              ok_ff, ok_in;
   logic [IDX_W-1:0]  found_ff, found_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              load_rsp;
   logic              out_free;

   rec_type           mem_ram [CAPACITY];
   rec_type           rd_data_ff;
   logic              rd_en, wr_en;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   rec_type           wr_data;

   logic [KEY_W-1:0]  req_key;
   logic [NAME_W-1:0] req_name;
   logic [AGE_W-1:0]  req_age;
   logic [OP_W-1:0]   req_op;

   logic              dir_up;
   logic [CNT_W-1:0]  step;
   logic [CNT_W-1:0]  adj_ptr;
   logic [IDX_W-1:0]  adj_key;
   logic [CNT_W-1:0]  list_next;

   assign req_key  = req_tdata[KEY_W-1:0];
   assign req_name = req_tdata[KEY_W+NAME_W-1:KEY_W];
   assign req_age  = req_tdata[KEY_W+NAME_W+AGE_W-1:KEY_W+NAME_W];
   assign req_op   = req_tuser[OP_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // shared +1/-1 unit for slot pointer and moved key
   assign dir_up    = (op_ff == OP_INSERT);
   assign step      = dir_up ? {CNT_W{1'b1}} : {{(CNT_W-1){1'b0}}, 1'b1};
   assign adj_ptr   = ptr_ff + step;
   assign adj_key   = rd_data_ff.key - step[IDX_W-1:0];
   assign list_next = ptr_ff + {{(CNT_W-1){1'b0}}, 1'b1};

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      ptr_in      = ptr_ff;
      tgt_in      = tgt_ff;
      name_in     = name_ff;
      age_in      = age_ff;
      ok_in       = ok_ff;
      found_in    = found_ff;
      count_in    = count_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      load_rsp    = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_op;
               tgt_in   = req_key[IDX_W-1:0];
               name_in  = req_name;
               age_in   = req_age;
               ok_in    = 1'b0;
               found_in = '0;
               state_in = ST_EMIT;
               case (req_op)
                  OP_INSERT: begin
                     if (count_ff < CNT_W'(CAPACITY) && !req_key[KEY_W-1] &&
                         req_key[KEY_W-2:0] <= count_ff) begin
                        ptr_in   = count_ff;
                        state_in = ST_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (!req_key[KEY_W-1] && req_key[KEY_W-2:0] < count_ff) begin
                        ptr_in   = {1'b0, req_key[IDX_W-1:0]};
                        state_in = ST_RD;
                     end
                  end
                  OP_SEARCH: begin
                     if (!req_key[KEY_W-1] && req_key[KEY_W-2:0] < count_ff) begin
                        ok_in    = 1'b1;
                        found_in = req_key[IDX_W-1:0];
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_LIST: begin
                     if (count_ff != '0) begin
                        ptr_in   = '0;
                        state_in = ST_LRD;
                     end
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_RD: begin
            if (dir_up) begin
               if (ptr_ff == {1'b0, tgt_ff}) begin
                  wr_en    = 1'b1;
                  wr_addr  = tgt_ff;
                  wr_data  = '{key: tgt_ff, name: name_ff, age: age_ff};
                  count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
                  ok_in    = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = adj_ptr[IDX_W-1:0];
                  state_in = ST_WR;
               end
            end else begin
               if (adj_ptr >= count_ff) begin
                  count_in = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};
                  ok_in    = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = adj_ptr[IDX_W-1:0];
                  state_in = ST_WR;
               end
            end
         end
         ST_WR: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff[IDX_W-1:0];
            wr_data  = '{key: adj_key, name: rd_data_ff.name, age: rd_data_ff.age};
            ptr_in   = adj_ptr;
            state_in = ST_RD;
         end
         ST_LRD: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff[IDX_W-1:0];
            state_in = ST_LEMIT;
         end
         ST_LEMIT: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_data_in = {4'b0, rd_data_ff.age, rd_data_ff.name, rd_data_ff.key,
                              count_ff, {IDX_W{1'b0}}, 1'b0};
               rsp_user_in = 1'b1;
               rsp_last_in = (list_next == count_ff);
               ptr_in      = list_next;
               state_in    = (list_next == count_ff) ? ST_IDLE : ST_LRD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_data_in = {4'b0, {AGE_W{1'b0}}, {NAME_W{1'b0}}, {IDX_W{1'b0}},
                              count_ff, found_ff, ok_ff};
               rsp_user_in = 1'b0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ptr_ff      <= ptr_in;
      tgt_ff      <= tgt_in;
      name_ff     <= name_in;
      age_ff      <= age_in;
      ok_ff       <= ok_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ram[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/prl_checker.sv
// Port-level checks for the positional record list, bound to the top level.
// Depends on prl_pkg and positional_record_list_top.
module prl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [prl_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [prl_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [prl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [prl_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input logic                            rsp_tlast
);
   import prl_pkg::*;

   logic [CNT_W-1:0] rsp_count;
   assign rsp_count = rsp_tdata[13:7];

   // stalled command beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) &&
      $stable(req_tuser))
      else $error("command beat changed while stalled");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= CNT_W'(CAPACITY))
      else $error("reported count above capacity");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata[95:14] == '0)
      else $error("command beat not marked last or carries entry data");

endmodule

bind positional_record_list_top prl_checker u_prl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/tb_positional_record_list_top.sv
// Self-checking testbench for positional_record_list_top: directed table, then random traffic.
// Predicts beats from its record list model or a directed row; depends on prl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_positional_record_list_top;
   import prl_pkg::*;

   localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

   localparam int RANDOM_ITEMS = 360;
   localparam int QUIET_TAIL   = 40;
   localparam int SETTLE_CYC   = 200;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic              ok;
      logic [IDX_W-1:0]  idx;
      logic [CNT_W-1:0]  cnt;
      logic              valid;
      logic [IDX_W-1:0]  ekey;
      logic [NAME_W-1:0] ename;
      logic [AGE_W-1:0]  eage;
      logic              last;
   } rsp_beat_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] name;
      logic [AGE_W-1:0]  age;
      bit                has_exp;
      rsp_beat_type      exp;
   } cmd_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   logic [IDX_W-1:0]  rec_key  [CAPACITY];
   logic [NAME_W-1:0] rec_name [CAPACITY];
   logic [AGE_W-1:0]  rec_age  [CAPACITY];
   int                rec_count;

   rsp_beat_type pending_rsp[$];
   cmd_row_type  directed_tab[$];
   int        mismatches;
   int        cycle_cnt;
   int        rsp_stall_left;
   bit        rsp_idle_en;
   int        gap_pct;

   positional_record_list_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int find_slot(int key);
      if (key < 0) return -1;
      for (int i = 0; i < rec_count; i++)
         if (rec_key[i] == key) return i;
      return -1;
   endfunction

   function automatic string beat_text(rsp_beat_type b);
      return $sformatf("ok=%0d idx=%0d cnt=%0d v=%0d key=%0d name=%h age=%0d last=%0d",
                       b.ok, b.idx, b.cnt, b.valid, b.ekey, b.ename, b.eage, b.last);
   endfunction

   task automatic apply_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key_raw,
                                input logic [NAME_W-1:0] name, input logic [AGE_W-1:0] age);
      int           key;
      int           pos;
      bit           listed;
      rsp_beat_type b;
      key    = $signed(key_raw);
      listed = 0;
      b      = '0;
      b.last = 1'b1;
      case (op)
         OP_INSERT: begin
            if (rec_count < CAPACITY && key >= 0 && key <= rec_count) begin
               for (int i = rec_count; i > key; i--) begin
                  rec_key[i]  = rec_key[i-1] + IDX_W'(1);
                  rec_name[i] = rec_name[i-1];
                  rec_age[i]  = rec_age[i-1];
               end
               rec_key[key]  = key[IDX_W-1:0];
               rec_name[key] = name;
               rec_age[key]  = age;
               rec_count++;
               b.ok = 1'b1;
            end
         end
         OP_DELETE: begin
            pos = find_slot(key);
            if (pos >= 0) begin
               for (int i = pos; i + 1 < rec_count; i++) begin
                  rec_key[i]  = rec_key[i+1] - IDX_W'(1);
                  rec_name[i] = rec_name[i+1];
                  rec_age[i]  = rec_age[i+1];
               end
               rec_count--;
               b.ok = 1'b1;
            end
         end
         OP_SEARCH: begin
            pos = find_slot(key);
            if (pos >= 0) begin
               b.ok  = 1'b1;
               b.idx = pos[IDX_W-1:0];
            end
         end
         OP_CLEAR: rec_count = 0;
         OP_LIST: begin
            for (int i = 0; i < rec_count; i++) begin
               b       = '0;
               b.cnt   = rec_count[CNT_W-1:0];
               b.valid = 1'b1;
               b.ekey  = rec_key[i];
               b.ename = rec_name[i];
               b.eage  = rec_age[i];
               b.last  = (i + 1 == rec_count);
               pending_rsp.push_back(b);
               listed = 1;
            end
         end
         default: ;
      endcase
      if (!listed) begin
         b.cnt = rec_count[CNT_W-1:0];
         pending_rsp.push_back(b);
      end
   endtask

   function automatic cmd_row_type cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                       logic [NAME_W-1:0] name, logic [AGE_W-1:0] age);
      cmd_row_type r;
      r.op      = op;
      r.key     = key;
      r.name    = name;
      r.age     = age;
      r.has_exp = 0;
      r.exp     = '0;
      return r;
   endfunction

   function automatic cmd_row_type cmd_exp(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                           logic [NAME_W-1:0] name, logic [AGE_W-1:0] age,
                                           logic ok, int idx, int cnt);
      cmd_row_type r;
      r          = cmd(op, key, name, age);
      r.has_exp  = 1;
      r.exp.ok   = ok;
      r.exp.idx  = idx[IDX_W-1:0];
      r.exp.cnt  = cnt[CNT_W-1:0];
      r.exp.last = 1'b1;
      return r;
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic send_cmd(cmd_row_type r);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {r.age, r.name, r.key};
      do @(posedge clock); while (!req_tready);
      apply_command(r.op, r.key, r.name, r.age);
      if (r.has_exp) begin
         void'(pending_rsp.pop_back());
         pending_rsp.push_back(r.exp);
      end
   endtask

   task automatic drain_rsp();
      idle_cycles(1);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [OP_W-1:0] pick_op(int phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         1: begin
            if (r < 35) return OP_INSERT;
            if (r < 60) return OP_DELETE;
            if (r < 80) return OP_SEARCH;
            if (r < 90) return OP_LIST;
            if (r < 94) return OP_W'($urandom_range(5, 7));
            if (r < 97) return OP_CLEAR;
            return OP_INSERT;
         end
         2: begin
            if (r < 15) return OP_INSERT;
            if (r < 75) return OP_DELETE;
            if (r < 88) return OP_SEARCH;
            if (r < 95) return OP_LIST;
            if (r < 98) return OP_W'($urandom_range(5, 7));
            return OP_CLEAR;
         end
         default: begin
            if (r < 80) return OP_INSERT;
            if (r < 85) return OP_DELETE;
            if (r < 92) return OP_SEARCH;
            if (r < 97) return OP_LIST;
            if (r < 99) return OP_W'($urandom_range(5, 7));
            return OP_CLEAR;
         end
      endcase
   endfunction

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else if (rsp_idle_en && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         rsp_stall_left = $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      rsp_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok    = rsp_tdata[0];
         got.idx   = rsp_tdata[6:1];
         got.cnt   = rsp_tdata[13:7];
         got.ekey  = rsp_tdata[19:14];
         got.ename = rsp_tdata[83:20];
         got.eage  = rsp_tdata[91:84];
         got.valid = rsp_tuser[0];
         got.last  = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: %s", beat_text(got));
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want || rsp_tdata[95:92] !== 4'd0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp: %s", beat_text(want));
                  $display("         got: %s pad=%h", beat_text(got), rsp_tdata[95:92]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      cmd_row_type     r;
      logic [OP_W-1:0] op;
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      rsp_stall_left = 0;
      rsp_idle_en    = 1;
      gap_pct        = 25;
      mismatches     = 0;
      cycle_cnt      = 0;
      rec_count      = 0;

      directed_tab.push_back(cmd_exp(OP_SEARCH, 8'd0, '0, '0, 0, 0, 0));
      directed_tab.push_back(cmd_exp(OP_LIST, 8'd0, '0, '0, 0, 0, 0));
      directed_tab.push_back(cmd_exp(OP_DELETE, 8'd0, '0, '0, 0, 0, 0));
      directed_tab.push_back(cmd_exp(OP_INSERT, 8'h80, '1, '1, 0, 0, 0));
      directed_tab.push_back(cmd_exp(OP_INSERT, 8'h7F, '1, '1, 0, 0, 0));
      directed_tab.push_back(cmd_exp(OP_INSERT, 8'd1, '1, '1, 0, 0, 0));
      directed_tab.push_back(cmd_exp(OP_INSERT, 8'd0, '1, 8'hFF, 1, 0, 1));
      directed_tab.push_back(cmd_exp(OP_INSERT, 8'd0, '0, 8'h00, 1, 0, 2));
      directed_tab.push_back(cmd_exp(OP_INSERT, 8'd2, 64'hA5A5_5A5A_0F0F_F0F0, 8'h80, 1, 0, 3));
      directed_tab.push_back(cmd_exp(OP_INSERT, 8'd1, 64'h0123_4567_89AB_CDEF, 8'h7F, 1, 0, 4));
      directed_tab.push_back(cmd(OP_LIST, 8'd0, '0, '0));
      directed_tab.push_back(cmd_exp(OP_SEARCH, 8'd3, '0, '0, 1, 3, 4));
      directed_tab.push_back(cmd_exp(OP_SEARCH, 8'h7F, '0, '0, 0, 0, 4));
      directed_tab.push_back(cmd_exp(OP_SEARCH, 8'hFF, '0, '0, 0, 0, 4));
      directed_tab.push_back(cmd_exp(OP_DELETE, 8'h80, '0, '0, 0, 0, 4));
      directed_tab.push_back(cmd_exp(OP_DELETE, 8'd0, '0, '0, 1, 0, 3));
      directed_tab.push_back(cmd_exp(OP_DELETE, 8'd2, '0, '0, 1, 0, 2));
      directed_tab.push_back(cmd(OP_LIST, 8'd0, '0, '0));
      directed_tab.push_back(cmd_exp(OP_RSVD_5, 8'hFF, '1, '1, 0, 0, 2));
      directed_tab.push_back(cmd_exp(OP_RSVD_6, 8'd0, '0, '0, 0, 0, 2));
      directed_tab.push_back(cmd_exp(OP_RSVD_7, 8'd1, '1, '1, 0, 0, 2));
      directed_tab.push_back(cmd_exp(OP_SEARCH, 8'd1, '0, '0, 1, 1, 2));
      directed_tab.push_back(cmd_exp(OP_CLEAR, 8'd0, '0, '0, 0, 0, 0));
      directed_tab.push_back(cmd_exp(OP_LIST, 8'd0, '0, '0, 0, 0, 0));
      directed_tab.push_back(cmd_exp(OP_INSERT, 8'd0, 64'h5A5A_A5A5_F0F0_0F0F, 8'h01, 1, 0, 1));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_tab[i]) begin
         if ($urandom_range(0, 99) < gap_pct) idle_cycles($urandom_range(1, 6));
         send_cmd(directed_tab[i]);
      end
      drain_rsp();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 30 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 15;
               default: gap_pct = 40;
            endcase
            rsp_idle_en = ($urandom_range(0, 3) != 0);
         end
         if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
            gap_pct     = 0;
            rsp_idle_en = 0;
         end
         if (n == RANDOM_ITEMS / 2) drain_rsp();
         op = pick_op((n / 90) % 3);
         r  = cmd(op, '0, {$urandom, $urandom}, AGE_W'($urandom_range(0, 255)));
         if (op == OP_INSERT && $urandom_range(0, 99) < 85)
            r.key = KEY_W'($urandom_range(0, rec_count));
         else if ((op == OP_DELETE || op == OP_SEARCH) && $urandom_range(0, 99) < 80)
            r.key = KEY_W'($urandom_range(0, rec_count));
         else
            r.key = KEY_W'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < gap_pct) idle_cycles($urandom_range(1, 6));
         send_cmd(r);
      end

      drain_rsp();
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
